[src/ordered_dither_pixel_packer_top_assert.svh]
// Assertion macros shared by the checker of the dither packer.
`ifndef ORDERED_DITHER_PIXEL_PACKER_TOP_ASSERT_SVH
`define ORDERED_DITHER_PIXEL_PACKER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ODPP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked from the cycle after the antecedent.
`define ODPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/odpp_pkg.sv]
// Shared types and constants of the ordered-dither pixel packer.
package odpp_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_GREY_MODE      = 3'd0;
	localparam logic [2:0] CFG_BITS_PER_PIXEL = 3'd1;
	localparam logic [2:0] CFG_RED_LEVELS     = 3'd2;
	localparam logic [2:0] CFG_GREEN_LEVELS   = 3'd3;
	localparam logic [2:0] CFG_BLUE_LEVELS    = 3'd4;
	localparam logic [2:0] CFG_GREY_LEVELS    = 3'd5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 9;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic pack;
	} odpp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic pack_blocked;
	} odpp_status_t;

endpackage

[src/odpp_datapath.sv]
// Datapath: configuration, level arithmetic, index packing and output byte register.
module odpp_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [odpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [odpp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [11:0]                         pixel_rgb,
	input  logic [1:0]                          column_phase,
	input  logic [1:0]                          row_phase,
	input  logic                                last_of_line,
	input  odpp_pkg::odpp_cmd_t                 cmd,
	output odpp_pkg::odpp_status_t              status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          packed_byte
);

	// Threshold matrix (bottom left entry is 14 by design)
	function automatic logic [3:0] thresh_lookup(input logic [1:0] row, input logic [1:0] col);
		logic [3:0] val;
		case ({row, col})
			4'h0: val = 4'd0;
			4'h1: val = 4'd8;
			4'h2: val = 4'd2;
			4'h3: val = 4'd10;
			4'h4: val = 4'd12;
			4'h5: val = 4'd4;
			4'h6: val = 4'd14;
			4'h7: val = 4'd6;
			4'h8: val = 4'd3;
			4'h9: val = 4'd11;
			4'hA: val = 4'd1;
			4'hB: val = 4'd9;
			4'hC: val = 4'd14;
			4'hD: val = 4'd7;
			4'hE: val = 4'd13;
			4'hF: val = 4'd5;
			default: val = 4'd0;
		endcase
		return val;
	endfunction

	// Divide by 15 through a reciprocal; exact for values up to 3840
	function automatic logic [8:0] div15(input logic [11:0] x);
		logic [24:0] prod;
		prod = (25'(x) + 25'd1) * 25'd4369;
		return prod[24:16];
	endfunction

	// Scale one component and apply the dither bump with clamp
	function automatic logic [3:0] comp_level(input logic [7:0] prod, input logic [3:0] top,
		input logic [3:0] d);
		logic [8:0] quot;
		logic [3:0] c;
		logic [7:0] rem;
		logic [4:0] bumped;
		quot = div15({4'b0, prod});
		c = quot[3:0];
		rem = prod - 8'({4'b0, c} * 8'd15);
		bumped = {1'b0, c} + ((rem[3:0] > d) ? 5'd1 : 5'd0);
		if (bumped > {1'b0, top}) begin
			bumped = {1'b0, top};
		end
		return bumped[3:0];
	endfunction

	// Clamp a colour level count to 1..16
	function automatic logic [4:0] clamp_colour(input logic [4:0] n);
		logic [4:0] v;
		if (n == 5'd0) begin
			v = 5'd1;
		end else if (n > 5'd16) begin
			v = 5'd16;
		end else begin
			v = n;
		end
		return v;
	endfunction

	logic             grey_mode_q;
	logic [3:0]       bits_per_pixel_q;
	logic [4:0]       red_levels_q;
	logic [4:0]       green_levels_q;
	logic [4:0]       blue_levels_q;
	logic [8:0]       grey_levels_q;

	logic [3:0]       bpp;
	logic [4:0]       nr;
	logic [4:0]       ng;
	logic [4:0]       nb;
	logic [8:0]       ngrey;
	logic [3:0]       top_r;
	logic [3:0]       top_g;
	logic [3:0]       top_b;
	logic [7:0]       top_grey;
	logic [7:0]       idx_mask;

	logic [11:0]      rgb_q;
	logic [3:0]       thr_q;
	logic             last_q;
	logic [3:0]       pr;
	logic [3:0]       pg;
	logic [3:0]       pb;

	logic [7:0]       prod_r_q;
	logic [7:0]       prod_g_q;
	logic [7:0]       prod_b_q;
	logic [11:0]      luma_sum_q;
	logic [3:0]       lvl_r_q;
	logic [3:0]       lvl_g_q;
	logic [3:0]       lvl_b_q;
	logic [8:0]       luma_q;
	logic [7:0]       cube_part_q;
	logic [15:0]      grey_prod_q;
	logic [7:0]       idx_q;

	logic [11:0]      cube_idx;
	logic [7:0]       grey_p;
	logic [7:0]       grey_q;
	logic [7:0]       grey_thr;
	logic [7:0]       grey_idx;
	logic [7:0]       idx_full;

	logic [7:0]       acc_q;
	logic [3:0]       rem_q;
	logic             fits;
	logic [7:0]       base_acc;
	logic [3:0]       base_rem;
	logic [3:0]       new_rem;
	logic [7:0]       new_acc;
	logic             emit;

	logic             out_valid_q;
	logic [7:0]       out_data_q;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grey_mode_q      <= 1'b0;
			bits_per_pixel_q <= 4'd8;
			red_levels_q     <= 5'd6;
			green_levels_q   <= 5'd7;
			blue_levels_q    <= 5'd6;
			grey_levels_q    <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				odpp_pkg::CFG_GREY_MODE:      grey_mode_q      <= cfg_data[0];
				odpp_pkg::CFG_BITS_PER_PIXEL: bits_per_pixel_q <= cfg_data[3:0];
				odpp_pkg::CFG_RED_LEVELS:     red_levels_q     <= cfg_data[4:0];
				odpp_pkg::CFG_GREEN_LEVELS:   green_levels_q   <= cfg_data[4:0];
				odpp_pkg::CFG_BLUE_LEVELS:    blue_levels_q    <= cfg_data[4:0];
				odpp_pkg::CFG_GREY_LEVELS:    grey_levels_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp register values to their working ranges
	always_comb begin
		if (bits_per_pixel_q == 4'd0) begin
			bpp = 4'd1;
		end else if (bits_per_pixel_q > 4'd8) begin
			bpp = 4'd8;
		end else begin
			bpp = bits_per_pixel_q;
		end
		nr = clamp_colour(red_levels_q);
		ng = clamp_colour(green_levels_q);
		nb = clamp_colour(blue_levels_q);
		if (grey_levels_q == 9'd0) begin
			ngrey = 9'd1;
		end else if (grey_levels_q > 9'd256) begin
			ngrey = 9'd256;
		end else begin
			ngrey = grey_levels_q;
		end
		top_r    = 4'(nr - 5'd1);
		top_g    = 4'(ng - 5'd1);
		top_b    = 4'(nb - 5'd1);
		top_grey = 8'(ngrey - 9'd1);
		idx_mask = 8'((9'd1 << bpp) - 9'd1);
	end

	// Capture the item and its threshold
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rgb_q  <= pixel_rgb;
			thr_q  <= thresh_lookup(row_phase, column_phase);
			last_q <= last_of_line;
		end
	end

	assign pr = rgb_q[11:8];
	assign pg = rgb_q[7:4];
	assign pb = rgb_q[3:0];

	// Step one: component products and weighted luma sum
	always_ff @(posedge clk) begin
		prod_r_q   <= {4'b0, pr} * {4'b0, top_r};
		prod_g_q   <= {4'b0, pg} * {4'b0, top_g};
		prod_b_q   <= {4'b0, pb} * {4'b0, top_b};
		luma_sum_q <= 12'(pr) * 12'd77 + 12'(pg) * 12'd151 + 12'(pb) * 12'd28;
	end

	// Step two: divide by 15 and dither each component
	always_ff @(posedge clk) begin
		lvl_r_q <= comp_level(prod_r_q, top_r, thr_q);
		lvl_g_q <= comp_level(prod_g_q, top_g, thr_q);
		lvl_b_q <= comp_level(prod_b_q, top_b, thr_q);
		luma_q  <= div15(luma_sum_q);
	end

	// Step three: first cube multiply and grey scaling product
	always_ff @(posedge clk) begin
		cube_part_q <= 8'({4'b0, lvl_r_q} * {3'b0, ng}) + {4'b0, lvl_g_q};
		grey_prod_q <= {7'b0, luma_q} * {8'b0, top_grey};
	end

	// Step four: finish the index in either mode and mask it
	always_comb begin
		cube_idx = {4'b0, cube_part_q} * {7'b0, nb} + {8'b0, lvl_b_q};
		grey_p   = grey_prod_q[15:8];
		grey_q   = grey_prod_q[7:0];
		grey_thr = {thr_q, 4'b0} + {4'b0, thr_q};
		grey_idx = grey_p;
		if ((grey_q > grey_thr) && (grey_p < top_grey)) begin
			grey_idx = grey_p + 8'd1;
		end
		idx_full = grey_mode_q ? grey_idx : cube_idx[7:0];
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_full & idx_mask;
	end

	// Work out the next packing state
	always_comb begin
		fits     = (bpp <= rem_q);
		base_acc = fits ? acc_q : 8'd0;
		base_rem = fits ? rem_q : 4'd8;
		new_rem  = base_rem - bpp;
		new_acc  = base_acc | 8'(idx_q << new_rem);
		emit     = (new_rem == 4'd0);
	end

	assign status.pack_blocked = emit && out_valid_q && !out_ready;

	// Advance the packer; restart after a full byte or the end of a line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 8'd0;
			rem_q <= 4'd8;
		end else if (cmd.pack) begin
			if (emit || last_q) begin
				acc_q <= 8'd0;
				rem_q <= 4'd8;
			end else begin
				acc_q <= new_acc;
				rem_q <= new_rem;
			end
		end
	end

	// Hold the finished byte until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pack && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pack && emit) begin
			out_data_q <= new_acc;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_byte = out_data_q;

endmodule

[src/odpp_ctrl.sv]
// Controller: sequences one item through the arithmetic steps and the packer.
module odpp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  odpp_pkg::odpp_status_t status,
	output odpp_pkg::odpp_cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_IDX1 = 6'b001000,
		ST_IDX2 = 6'b010000,
		ST_PACK = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   pack_go;
	logic   accept;

	// Pack unless the step completes a byte while the byte register is still full
	assign pack_go     = (state_q == ST_PACK) && !status.pack_blocked;
	assign in_ready    = (state_q == ST_IDLE) || pack_go;
	assign accept      = in_valid && in_ready;
	assign cmd.capture = accept;
	assign cmd.pack    = pack_go;

	// Step through the sequence
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL:  state_nxt = ST_DIV;
			ST_DIV:  state_nxt = ST_IDX1;
			ST_IDX1: state_nxt = ST_IDX2;
			ST_IDX2: state_nxt = ST_PACK;
			ST_PACK: begin
				if (accept) begin
					state_nxt = ST_MUL;
				end else if (pack_go) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[src/ordered_dither_pixel_packer_top.sv]
// Top level of the ordered-dither pixel packer.
// Input channel (in_valid/in_ready): one RGB444 pixel with its column and row phase
// and an end-of-line flag per item. Output channel (out_valid/out_ready): one packed
// byte of palette indices, first pixel in the most significant bits.
// Configuration: cfg_we writes cfg_data into register cfg_index at once (grey_mode,
// bits_per_pixel, red/green/blue_levels, grey_levels); write only while idle.
// An item is taken only while idle or in the packer step of the item before; each
// goes through the controller's sequence of product, divide-by-15, two index
// multiplies and the packer update. A byte that an item completes shows on out_valid
// once its packer step registers it. Items that do not fill a byte give no output.
// The byte register lets the next item enter while a byte waits; if the receiver
// stalls and a further byte is ready, the packer step holds and in_ready stays low.
// Reset clears the packer to an empty byte, drops any waiting byte and loads the
// register defaults (colour mode, 8 bits, 6x7x6 cube, 256 grey levels).
module ordered_dither_pixel_packer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [odpp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [odpp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [11:0]                      pixel_rgb,
	input  logic [1:0]                       column_phase,
	input  logic [1:0]                       row_phase,
	input  logic                             last_of_line,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       packed_byte
);

	odpp_pkg::odpp_cmd_t    cmd;
	odpp_pkg::odpp_status_t status;

	// Sequence control
	odpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and packing
	odpp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_rgb    (pixel_rgb),
		.column_phase (column_phase),
		.row_phase    (row_phase),
		.last_of_line (last_of_line),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packed_byte  (packed_byte)
	);

endmodule

[src/odpp_checker.sv]
// Port-level checks on the dither packer and their binding to the top level.
`include "ordered_dither_pixel_packer_top_assert.svh"

module odpp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] packed_byte
);

	logic in_acc;
	logic out_stall;
	logic rdy_d1_q;
	logic rdy_d2_q;

	assign in_acc    = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	// Keep the last two values of in_ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_d1_q <= 1'b0;
			rdy_d2_q <= 1'b0;
		end else begin
			rdy_d1_q <= in_ready;
			rdy_d2_q <= rdy_d1_q;
		end
	end

	// A stalled byte stays offered and unchanged
	`ODPP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(packed_byte), "byte changed")

	// An accepted item keeps the input closed through the arithmetic steps
	`ODPP_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready [*4], "input reopened too early")

	// A new byte appears only from a packer step, which reopens the input
	`ODPP_ASSERT_SAME(a_byte_from_pack, $rose(out_valid), rdy_d1_q && !rdy_d2_q, "no packer step")

endmodule

bind ordered_dither_pixel_packer_top odpp_checker u_odpp_checker (.*);

[tb/tb.sv]
// Self-checking testbench for the ordered-dither pixel packer.
module tb;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 12;
	localparam int TAIL_CYCLES     = 20;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 137;
	localparam int DIRECTED_ROWS   = 38;
	localparam int IDX_W           = odpp_pkg::CFG_INDEX_W;
	localparam int DAT_W           = odpp_pkg::CFG_DATA_W;

	// 4x4 threshold matrix, entry (row, col) at nibble row*4+col
	localparam logic [63:0] BAYER4 = {
		4'd5, 4'd13, 4'd7, 4'd14, 4'd9, 4'd1, 4'd11, 4'd3,
		4'd6, 4'd14, 4'd4, 4'd12, 4'd10, 4'd2, 4'd8, 4'd0
	};

	typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;
	typedef enum int {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

	typedef struct {
		row_kind_t               kind;
		logic [IDX_W-1:0]        reg_idx;
		logic [DAT_W-1:0]        reg_val;
		logic [11:0]             rgb;
		logic [1:0]              col;
		logic [1:0]              row;
		logic                    last;
		bit                      typed;
		logic [7:0]              typed_val;
	} stim_row_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_we       = 1'b0;
	logic [IDX_W-1:0]       cfg_index    = '0;
	logic [DAT_W-1:0]       cfg_data     = '0;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	logic [11:0]            pixel_rgb    = '0;
	logic [1:0]             column_phase = '0;
	logic [1:0]             row_phase    = '0;
	logic                   last_of_line = 1'b0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic [7:0]             packed_byte;

	// Typed expectation travelling with the item on the input channel
	bit         want_typed = 1'b0;
	logic [7:0] typed_byte = '0;

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int cycle_count     = 0;
	int fail_count      = 0;

	logic [7:0] expected_bytes[$];

	// Predictor copy of the registers and the packer
	logic        mode_grey  = 1'b0;
	logic [3:0]  width_cfg  = 4'd8;
	logic [4:0]  lv_red     = 5'd6;
	logic [4:0]  lv_green   = 5'd7;
	logic [4:0]  lv_blue    = 5'd6;
	logic [8:0]  lv_grey    = 9'd256;
	logic [7:0]  acc_byte   = 8'h00;
	int unsigned acc_room   = 8;

	stim_row_t directed [DIRECTED_ROWS];

	ordered_dither_pixel_packer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_rgb    (pixel_rgb),
		.column_phase (column_phase),
		.row_phase    (row_phase),
		.last_of_line (last_of_line),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packed_byte  (packed_byte)
	);

	always #4 clk = ~clk;

	function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Scale one 4-bit component to top+1 levels, bumping past the threshold
	function automatic int unsigned cube_level(int unsigned v, int unsigned top,
			int unsigned d);
		int unsigned prod, c, q;
		prod = v * top;
		c = prod / 15;
		q = prod - 15 * c;
		if (q > d) c++;
		if (c > top) c = top;
		return c;
	endfunction

	// Dither one pixel, pack its index and return 1 when a byte completes
	function automatic bit dither_pack(input logic [11:0] rgb, input logic [1:0] col,
			input logic [1:0] row, input logic last, output logic [7:0] full_byte);
		int unsigned r, g, b, d, width, top, y, prod, p, nr, ng, nb, idx;
		bit emit;
		r = rgb[11:8];
		g = rgb[7:4];
		b = rgb[3:0];
		d = BAYER4[(int'(row) * 4 + int'(col)) * 4 +: 4];
		width = clamp_u(width_cfg, 1, 8);
		full_byte = 8'h00;
		emit = 1'b0;
		if (mode_grey) begin
			top = clamp_u(lv_grey, 1, 256) - 1;
			y = (77 * r + 151 * g + 28 * b) / 15;
			prod = y * top;
			p = prod >> 8;
			if ((prod & 255) > d * 17 && p < top) p++;
			idx = p;
		end else begin
			nr = clamp_u(lv_red, 1, 16);
			ng = clamp_u(lv_green, 1, 16);
			nb = clamp_u(lv_blue, 1, 16);
			idx = (cube_level(r, nr - 1, d) * ng + cube_level(g, ng - 1, d)) * nb
				+ cube_level(b, nb - 1, d);
		end
		idx &= (1 << width) - 1;
		// Drop the partial byte when the index does not fit
		if (width > acc_room) begin
			acc_byte = 8'h00;
			acc_room = 8;
		end
		acc_room -= width;
		acc_byte = acc_byte | 8'(idx << acc_room);
		if (acc_room == 0) begin
			full_byte = acc_byte;
			emit = 1'b1;
			acc_byte = 8'h00;
			acc_room = 8;
		end
		if (last) begin
			acc_byte = 8'h00;
			acc_room = 8;
		end
		return emit;
	endfunction

	function automatic stim_row_t cfg_row(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] val);
		stim_row_t s;
		s = '{ROW_CFG, idx, val, 12'h000, 2'd0, 2'd0, 1'b0, 1'b0, 8'h00};
		return s;
	endfunction

	function automatic stim_row_t pix_row(logic [11:0] rgb, logic [1:0] col, logic [1:0] row,
			logic last, bit typed, logic [7:0] val);
		stim_row_t s;
		s = '{ROW_PIXEL, '0, '0, rgb, col, row, last, typed, val};
		return s;
	endfunction

	// Hold the sender, wait for every byte and let the pipeline settle
	task automatic drain_block();
		@(negedge clk) in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] val);
		@(negedge clk) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
		end
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(input logic [11:0] rgb, input logic [1:0] col, input logic [1:0] row,
			input logic last, input bit typed, input logic [7:0] typed_val);
		while ($urandom_range(99) < sender_idle_pct) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk) begin
			in_valid     <= 1'b1;
			pixel_rgb    <= rgb;
			column_phase <= col;
			row_phase    <= row;
			last_of_line <= last;
			want_typed   <= typed;
			typed_byte   <= typed_val;
		end
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL: begin
				sender_idle_pct = 0;
				recv_stall_pct  = 0;
			end
			PACE_SENDER_IDLE: begin
				sender_idle_pct = 88;
				recv_stall_pct  = 0;
			end
			PACE_RECEIVER_STALL: begin
				sender_idle_pct = 0;
				recv_stall_pct  = 88;
			end
			default: begin
				sender_idle_pct = 9;
				recv_stall_pct  = 9;
			end
		endcase
	endtask

	// Receiver back-pressure
	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Scoreboard: check bytes, track register writes, predict accepted items
	always @(posedge clk) begin : scoreboard
		logic [7:0] pred_byte;
		logic [7:0] want;
		bit         produced;
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** ordered_dither_pixel_packer_top: FAILED **");
			$finish;
		end else if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$error("packed_byte: no item waiting, got %02h", packed_byte);
					fail_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (packed_byte !== want) begin
						$error("packed_byte: expected %02h, got %02h", want, packed_byte);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					odpp_pkg::CFG_GREY_MODE:      mode_grey = cfg_data[0];
					odpp_pkg::CFG_BITS_PER_PIXEL: width_cfg = cfg_data[3:0];
					odpp_pkg::CFG_RED_LEVELS:     lv_red    = cfg_data[4:0];
					odpp_pkg::CFG_GREEN_LEVELS:   lv_green  = cfg_data[4:0];
					odpp_pkg::CFG_BLUE_LEVELS:    lv_blue   = cfg_data[4:0];
					odpp_pkg::CFG_GREY_LEVELS:    lv_grey   = cfg_data[8:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				produced = dither_pack(pixel_rgb, column_phase, row_phase, last_of_line,
					pred_byte);
				if (want_typed)
					expected_bytes.push_back(typed_byte);
				else if (produced)
					expected_bytes.push_back(pred_byte);
			end
		end
	end

	initial begin
		int          x_pos;
		int          y_line;
		int          line_left;
		logic [1:0]  col;
		logic [1:0]  row;
		logic        last;
		logic [8:0]  bpp_val;

		// Directed table: reset defaults, grey extremes, level and width clamps, packing cases
		directed = '{
			pix_row(12'h000, 2'd0, 2'd0, 1'b0, 1'b1, 8'h00),
			pix_row(12'hFFF, 2'd3, 2'd3, 1'b0, 1'b1, 8'hFB),
			pix_row(12'h8A5, 2'd1, 2'd2, 1'b0, 1'b0, 8'h00),
			pix_row(12'h7F0, 2'd2, 2'd1, 1'b1, 1'b0, 8'h00),
			cfg_row(odpp_pkg::CFG_GREY_MODE, 9'd1),
			pix_row(12'hFFF, 2'd0, 2'd0, 1'b0, 1'b1, 8'hFF),
			pix_row(12'h000, 2'd2, 2'd3, 1'b0, 1'b1, 8'h00),
			pix_row(12'h5A3, 2'd3, 2'd2, 1'b1, 1'b0, 8'h00),
			cfg_row(odpp_pkg::CFG_GREY_LEVELS, 9'd0),
			pix_row(12'hFFF, 2'd1, 2'd3, 1'b0, 1'b1, 8'h00),
			cfg_row(odpp_pkg::CFG_GREY_LEVELS, 9'd511),
			pix_row(12'h7C4, 2'd1, 2'd1, 1'b0, 1'b0, 8'h00),
			cfg_row(odpp_pkg::CFG_BITS_PER_PIXEL, 9'd0),
			pix_row(12'hFFF, 2'd0, 2'd1, 1'b0, 1'b0, 8'h00),
			pix_row(12'h000, 2'd1, 2'd1, 1'b0, 1'b0, 8'h00),
			pix_row(12'hFFF, 2'd2, 2'd1, 1'b1, 1'b0, 8'h00),
			cfg_row(odpp_pkg::CFG_BITS_PER_PIXEL, 9'd3),
			pix_row(12'h9E2, 2'd0, 2'd0, 1'b0, 1'b0, 8'h00),
			pix_row(12'h3B6, 2'd1, 2'd0, 1'b0, 1'b0, 8'h00),
			pix_row(12'hC41, 2'd2, 2'd0, 1'b0, 1'b0, 8'h00),
			cfg_row(odpp_pkg::CFG_BITS_PER_PIXEL, 9'd4),
			pix_row(12'h6D8, 2'd3, 2'd0, 1'b0, 1'b0, 8'h00),
			pix_row(12'h25F, 2'd0, 2'd2, 1'b0, 1'b0, 8'h00),
			pix_row(12'hE07, 2'd1, 2'd2, 1'b0, 1'b0, 8'h00),
			cfg_row(odpp_pkg::CFG_GREY_MODE, 9'd0),
			cfg_row(odpp_pkg::CFG_BITS_PER_PIXEL, 9'd15),
			cfg_row(odpp_pkg::CFG_RED_LEVELS, 9'd0),
			cfg_row(odpp_pkg::CFG_GREEN_LEVELS, 9'd31),
			cfg_row(odpp_pkg::CFG_BLUE_LEVELS, 9'd16),
			pix_row(12'hFFF, 2'd2, 2'd2, 1'b0, 1'b1, 8'hFF),
			cfg_row(odpp_pkg::CFG_RED_LEVELS, 9'd16),
			pix_row(12'hFFF, 2'd3, 2'd1, 1'b0, 1'b1, 8'hFF),
			pix_row(12'h1A7, 2'd0, 2'd0, 1'b0, 1'b0, 8'h00),
			cfg_row(odpp_pkg::CFG_BITS_PER_PIXEL, 9'd2),
			pix_row(12'h3C9, 2'd1, 2'd3, 1'b0, 1'b0, 8'h00),
			pix_row(12'hB52, 2'd2, 2'd3, 1'b0, 1'b0, 8'h00),
			pix_row(12'hF0E, 2'd3, 2'd3, 1'b0, 1'b0, 8'h00),
			pix_row(12'h48D, 2'd0, 2'd3, 1'b1, 1'b0, 8'h00)
		};

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		set_pace(PACE_FULL);
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed[i].kind == ROW_CFG) begin
				drain_block();
				write_reg(directed[i].reg_idx, directed[i].reg_val);
			end else begin
				send_pixel(directed[i].rgb, directed[i].col, directed[i].row, directed[i].last,
					directed[i].typed, directed[i].typed_val);
			end
		end

		// Random phases: fresh settings each phase, mostly well-formed lines
		x_pos = 0;
		y_line = 0;
		line_left = 0;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_block();
			set_pace(pace_t'(ph % 4));
			case (ph)
				0: begin
					write_reg(odpp_pkg::CFG_GREY_MODE, 9'd0);
					write_reg(odpp_pkg::CFG_BITS_PER_PIXEL, 9'd1);
					write_reg(odpp_pkg::CFG_RED_LEVELS, 9'd1);
					write_reg(odpp_pkg::CFG_GREEN_LEVELS, 9'd1);
					write_reg(odpp_pkg::CFG_BLUE_LEVELS, 9'd1);
					write_reg(odpp_pkg::CFG_GREY_LEVELS, 9'd1);
				end
				1: begin
					write_reg(odpp_pkg::CFG_GREY_MODE, 9'd1);
					write_reg(odpp_pkg::CFG_BITS_PER_PIXEL, 9'd8);
					write_reg(odpp_pkg::CFG_RED_LEVELS, 9'd16);
					write_reg(odpp_pkg::CFG_GREEN_LEVELS, 9'd16);
					write_reg(odpp_pkg::CFG_BLUE_LEVELS, 9'd16);
					write_reg(odpp_pkg::CFG_GREY_LEVELS, 9'd256);
				end
				2: begin
					write_reg(odpp_pkg::CFG_GREY_MODE, 9'd0);
					write_reg(odpp_pkg::CFG_BITS_PER_PIXEL, 9'd15);
					write_reg(odpp_pkg::CFG_RED_LEVELS, 9'd31);
					write_reg(odpp_pkg::CFG_GREEN_LEVELS, 9'd31);
					write_reg(odpp_pkg::CFG_BLUE_LEVELS, 9'd31);
					write_reg(odpp_pkg::CFG_GREY_LEVELS, 9'd511);
				end
				3: begin
					write_reg(odpp_pkg::CFG_GREY_MODE, 9'd1);
					write_reg(odpp_pkg::CFG_BITS_PER_PIXEL, 9'd0);
					write_reg(odpp_pkg::CFG_RED_LEVELS, 9'd0);
					write_reg(odpp_pkg::CFG_GREEN_LEVELS, 9'd0);
					write_reg(odpp_pkg::CFG_BLUE_LEVELS, 9'd0);
					write_reg(odpp_pkg::CFG_GREY_LEVELS, 9'd0);
				end
				default: begin
					if ($urandom_range(3) != 0)
						bpp_val = 9'(1 << $urandom_range(0, 3));
					else
						bpp_val = 9'($urandom_range(0, 15));
					write_reg(odpp_pkg::CFG_GREY_MODE, 9'($urandom_range(0, 1)));
					write_reg(odpp_pkg::CFG_BITS_PER_PIXEL, bpp_val);
					write_reg(odpp_pkg::CFG_RED_LEVELS, 9'($urandom_range(0, 31)));
					write_reg(odpp_pkg::CFG_GREEN_LEVELS, 9'($urandom_range(0, 31)));
					write_reg(odpp_pkg::CFG_BLUE_LEVELS, 9'($urandom_range(0, 31)));
					write_reg(odpp_pkg::CFG_GREY_LEVELS, 9'($urandom_range(0, 511)));
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Hold the sender until the block has handed over every byte
				if (n == ITEMS_PER_PHASE / 2) begin
					@(negedge clk) in_valid <= 1'b0;
					while (expected_bytes.size() != 0) @(negedge clk);
				end
				if (line_left == 0) begin
					line_left = $urandom_range(1, 48);
					x_pos = $urandom_range(0, 3);
					y_line++;
				end
				if ($urandom_range(99) < 85) begin
					col = x_pos[1:0];
					row = y_line[1:0];
					last = (line_left == 1);
					x_pos++;
					line_left--;
				end else begin
					col = 2'($urandom_range(0, 3));
					row = 2'($urandom_range(0, 3));
					last = ($urandom_range(7) == 0);
				end
				send_pixel(12'($urandom_range(0, 4095)), col, row, last, 1'b0, 8'h00);
			end
		end

		// Wait for the last bytes, then let the pipeline settle
		@(negedge clk) in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("** ordered_dither_pixel_packer_top: PASSED **");
		else
			$display("** ordered_dither_pixel_packer_top: FAILED **");
		$finish;
	end

endmodule
